// File: hdl/cfl_pkg.sv
// shared types and constants for the cfl time step reduction block
// word and fraction widths, request and result layouts, controller codes
// no dependencies
package cfl_pkg;

    // fixed point format of the word values: unsigned or signed q16.16
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0]        word_t;
    typedef logic signed [WORD_BITS-1:0] sword_t;
    typedef logic [CNT_BITS-1:0]         step_cnt_t;

    // time of an axis that nothing limits, also the saturation value
    localparam word_t INFINITY = '1;

    // reset cell width, 1.0 in fixed point
    localparam word_t WIDTH_ONE = word_t'(1) << FRAC_BITS;

    // last quotient bit step of the divider lanes
    localparam step_cnt_t LAST_STEP = step_cnt_t'(WORD_BITS - 1);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CELL_WIDTH_X = 1'b0,
        CFG_CELL_WIDTH_Y = 1'b1
    } cfg_idx_t;

    // one cell request
    typedef struct packed {
        sword_t                 x_velocity;
        sword_t                 y_velocity;
        logic [WORD_BITS-2:0]   sound_speed;
        logic                   in_domain;
        logic                   last_cell;
    } cell_req_t;

    // one result
    typedef struct packed {
        word_t  time_step;
        logic   no_limit;
    } step_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic div_first;
        logic update;
        logic emit;
    } cfl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_domain;
        logic last_cell;
    } cfl_status_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_EMIT = 5'b10000
    } cfl_state_t;

endpackage

// File: hdl/cfl_div_lane.sv
// one restoring divider lane: floor((width << FRAC_BITS) / speed), one bit a cycle
// flags quotients that do not fit the word
// depends on cfl_pkg
module cfl_div_lane (
    input  logic          clk,
    input  logic          start,
    input  logic          step,
    input  logic          first,
    input  cfl_pkg::word_t width,
    input  cfl_pkg::word_t speed,
    output cfl_pkg::word_t quotient,
    output logic          overflow
);
    import cfl_pkg::*;

    word_t              rem_reg;
    word_t              rem_next;
    word_t              low_reg;
    word_t              quot_reg;
    logic               ovf_reg;
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    logic               take;

    // trial subtraction of the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, low_reg[WORD_BITS-1]};
        diff     = trial - {1'b0, speed};
        take     = (trial >= {1'b0, speed});
        rem_next = take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    end

    // upper word of the numerator seeds the remainder, lower word shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= width >> (WORD_BITS - FRAC_BITS);
            low_reg <= width << FRAC_BITS;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[WORD_BITS-2:0], take};
        end
    end

    // quotient too wide when the upper numerator word is not below the divisor
    always_ff @(posedge clk)
    begin
        if (step && first)
        begin
            ovf_reg <= (rem_reg >= speed);
        end
    end

    assign quotient = quot_reg;
    assign overflow = ovf_reg;

endmodule

// File: hdl/cfl_datapath.sv
// datapath: config registers, wave speeds, two divider lanes, running minimum
// and result register
// depends on cfl_pkg and cfl_div_lane
module cfl_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cfl_pkg::cfl_cmd_t    cmd,
    output cfl_pkg::cfl_status_t status,
    input  cfl_pkg::cell_req_t   in_data,
    output cfl_pkg::step_rsp_t   out_data,
    input  logic                cfg_write,
    input  cfl_pkg::cfg_idx_t    cfg_index,
    input  cfl_pkg::word_t       cfg_data
);
    import cfl_pkg::*;

    word_t                cell_width_x_reg;
    word_t                cell_width_y_reg;
    word_t                x_mag_reg;
    word_t                y_mag_reg;
    logic [WORD_BITS-2:0] c_reg;
    logic                 in_domain_reg;
    logic                 last_cell_reg;
    word_t                x_speed_reg;
    word_t                y_speed_reg;
    word_t                running_min_reg;
    word_t                running_min_next;
    logic                 any_limited_reg;
    step_rsp_t            result_reg;
    word_t                x_quot;
    word_t                y_quot;
    logic                 x_ovf;
    logic                 y_ovf;
    word_t                cand_x;
    word_t                cand_y;
    logic                 x_lt_y;
    logic                 x_lt_min;
    logic                 y_lt_min;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_x_reg <= WIDTH_ONE;
            cell_width_y_reg <= WIDTH_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CELL_WIDTH_X: cell_width_x_reg <= cfg_data;
                CFG_CELL_WIDTH_Y: cell_width_y_reg <= cfg_data;
                default:          cell_width_x_reg <= cell_width_x_reg;
            endcase
        end
    end

    // capture the request: velocity magnitudes, sound speed and the two flags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_mag_reg <= in_data.x_velocity[WORD_BITS-1] ? word_t'(-in_data.x_velocity)
                                                         : word_t'(in_data.x_velocity);
            y_mag_reg <= in_data.y_velocity[WORD_BITS-1] ? word_t'(-in_data.y_velocity)
                                                         : word_t'(in_data.y_velocity);
            c_reg         <= in_data.sound_speed;
            in_domain_reg <= in_data.in_domain;
            last_cell_reg <= in_data.last_cell;
        end
    end

    // wave speeds |u| + c and |v| + c, these never exceed the word
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            x_speed_reg <= x_mag_reg + {1'b0, c_reg};
            y_speed_reg <= y_mag_reg + {1'b0, c_reg};
        end
    end

    assign status.in_domain = in_domain_reg;
    assign status.last_cell = last_cell_reg;

    // x and y divider lanes run side by side
    cfl_div_lane u_div_x (
        .clk      (clk),
        .start    (cmd.prep),
        .step     (cmd.div_step),
        .first    (cmd.div_first),
        .width    (cell_width_x_reg),
        .speed    (x_speed_reg),
        .quotient (x_quot),
        .overflow (x_ovf)
    );

    cfl_div_lane u_div_y (
        .clk      (clk),
        .start    (cmd.prep),
        .step     (cmd.div_step),
        .first    (cmd.div_first),
        .width    (cell_width_y_reg),
        .speed    (y_speed_reg),
        .quotient (y_quot),
        .overflow (y_ovf)
    );

    // candidate times, a zero wave speed gives no candidate
    always_comb
    begin
        cand_x   = (x_speed_reg == '0) ? INFINITY : (x_ovf ? INFINITY : x_quot);
        cand_y   = (y_speed_reg == '0) ? INFINITY : (y_ovf ? INFINITY : y_quot);
        x_lt_y   = (cand_x < cand_y);
        x_lt_min = (cand_x < running_min_reg);
        y_lt_min = (cand_y < running_min_reg);
        if (x_lt_y && x_lt_min)
        begin
            running_min_next = cand_x;
        end
        else if (!x_lt_y && y_lt_min)
        begin
            running_min_next = cand_y;
        end
        else
        begin
            running_min_next = running_min_reg;
        end
    end

    // running minimum, cleared when the result leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_min_reg <= INFINITY;
            any_limited_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            running_min_reg <= INFINITY;
            any_limited_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            running_min_reg <= running_min_next;
            any_limited_reg <= any_limited_reg | (x_speed_reg != '0) | (y_speed_reg != '0);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.time_step <= running_min_reg;
            result_reg.no_limit  <= !any_limited_reg;
        end
    end

    assign out_data = result_reg;

    // the minimum never rises during a range
    a_min_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && !cmd.emit |=> running_min_reg <= $past(running_min_reg))
        else $error("running minimum rose on an update");

    // a result restarts the range
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> running_min_reg == INFINITY && !any_limited_reg)
        else $error("range state not cleared after a result");

    // a result carries the state of the range it closes
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_data.time_step == $past(running_min_reg)
            && out_data.no_limit == !$past(any_limited_reg))
        else $error("result does not match the range state");

endmodule

// File: hdl/cfl_ctrl.sv
// controller state machine: request accept, divider sequencing, result hand-off
// drives the output valid and the input stall
// depends on cfl_pkg
module cfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  cfl_pkg::cfl_status_t status,
    output cfl_pkg::cfl_cmd_t    cmd
);
    import cfl_pkg::*;

    cfl_state_t state_reg;
    cfl_state_t state_next;
    step_cnt_t  count_reg;
    step_cnt_t  count_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                count_next = '0;
                if (status.in_domain)
                begin
                    state_next = ST_DIV;
                end
                else if (status.last_cell)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (count_reg == '0);
                count_next    = count_reg + step_cnt_t'(1);
                if (count_reg == LAST_STEP)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.update = 1'b1;
                state_next = status.last_cell ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // an accepted request always goes to preparation
    a_load_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_PREP)
        else $error("accepted request did not enter preparation");

    // the divider stops after exactly one word of quotient bits
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && count_reg == LAST_STEP |=> state_reg == ST_CMP)
        else $error("divider did not finish after the last step");

    // a result waits while the previous one is still held
    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_valid_reg && out_stall |=> state_reg == ST_EMIT)
        else $error("result overwrote a held result");

    // no new result while one is held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result emitted into a full output register");

endmodule

// File: hdl/cfl_timestep_min_reduction.sv
// Top level of the cfl time step reduction block.
// Request channel (in_valid, in_stall, in_data): one grid cell per request with
// x and y velocity (signed q16.16), sound speed (q15.16), in-domain and last-cell
// bits. Result channel (out_valid, out_stall, out_data): one result per range,
// sent after the request carrying last_cell, with the minimum time step in
// q16.16 (all ones when saturated or unlimited) and a no-limit flag.
// Configuration: cfg_write with cfg_index selects cell_width_x or cell_width_y.
// Sequence: a cell in the domain holds the request channel through accept,
// wave speed add, the quotient bit steps of the two divider lanes and the
// minimum update, and the last cell of a range also through the result load.
// A masked cell passes only accept and wave speed add, plus the result load
// when it ends a range. The two restoring divider lanes do one quotient bit per cycle each.
// A result is visible on the cycle after it is loaded and is held in an output
// register, so a stalled receiver does not stop the next range from being
// worked on; only the load of the following result waits for the register.
// Reset clears the running minimum to all ones, cell widths to 1.0 and the
// output valid.
// depends on cfl_pkg, cfl_ctrl, cfl_datapath
module cfl_timestep_min_reduction (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cfl_pkg::cell_req_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cfl_pkg::step_rsp_t out_data,
    input  logic              cfg_write,
    input  cfl_pkg::cfg_idx_t  cfg_index,
    input  cfl_pkg::word_t     cfg_data
);
    import cfl_pkg::*;

    cfl_cmd_t    cmd;
    cfl_status_t status;

    // controller
    cfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    cfl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
